/* sv/adsr_envelope_generator_assert.svh */
// Assertion macros for the envelope generator.
// ADSR_ASSERT_IMP: same-cycle implication, ADSR_ASSERT_NXT: next-cycle implication.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ADSR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("adsr assertion failed");
`define ADSR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("adsr assertion failed");
`else
`define ADSR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ADSR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* sv/adsr_pkg.sv */
package adsr_pkg;

  // Envelope level scale
  localparam int unsigned ACC_W    = 19;
  localparam int unsigned KNOB_W   = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned SUS_SHIFT = 11;
  localparam logic [ACC_W-1:0] ENV_CAP = 19'd522240;

  // Step widths
  localparam int unsigned ATK_W = 13;
  localparam int unsigned DEC_W = 19;
  localparam int unsigned REL_W = 13;

  // Step derivation constants
  localparam logic [12:0] ATK_NUM   = 13'd4874;
  localparam logic [6:0]  DEC_SCALE = 7'd107;
  localparam int unsigned REL_SHIFT = 19;

  // Shared divider geometry
  localparam int unsigned DIV_BITS = 32;
  localparam int unsigned DSR_W    = 19;
  localparam int unsigned CNT_W    = $clog2(DIV_BITS);

  // Knob reset values
  localparam logic [KNOB_W-1:0] ATTACK_RST  = 8'd3;
  localparam logic [KNOB_W-1:0] DECAY_RST   = 8'd20;
  localparam logic [KNOB_W-1:0] SUSTAIN_RST = 8'd200;
  localparam logic [KNOB_W-1:0] RELEASE_RST = 8'd20;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  // Phase codes seen on the result channel
  localparam logic [PHASE_W-1:0] PH_INACTIVE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd4;

  typedef enum logic [4:0] {
    ENV_INACTIVE = 5'b00001,
    ENV_ATTACK   = 5'b00010,
    ENV_DECAY    = 5'b00100,
    ENV_SUSTAIN  = 5'b01000,
    ENV_RELEASE  = 5'b10000
  } env_phase_t;

  typedef struct packed {
    logic [KNOB_W-1:0] attack;
    logic [KNOB_W-1:0] decay;
    logic [KNOB_W-1:0] sustain;
    logic [KNOB_W-1:0] rel;
  } adsr_knobs_t;

  typedef struct packed {
    logic             busy;
    logic [ATK_W-1:0] atk_step;
    logic [DEC_W-1:0] dec_step;
    logic [REL_W-1:0] rel_step;
  } adsr_steps_t;

  // knob*16 + 1
  function automatic logic [11:0] knob_div(input logic [KNOB_W-1:0] knob);
    return {knob, 4'b0001};
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input env_phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      ENV_INACTIVE: code = PH_INACTIVE;
      ENV_ATTACK:   code = PH_ATTACK;
      ENV_DECAY:    code = PH_DECAY;
      ENV_SUSTAIN:  code = PH_SUSTAIN;
      ENV_RELEASE:  code = PH_RELEASE;
      default:      code = PH_INACTIVE;
    endcase
    return code;
  endfunction

endpackage

/* sv/adsr_if.sv */
// Command channel: valid/ready with one command item
interface adsr_in_if;
  logic valid;
  logic ready;
  logic command;
  logic gate;

  modport source (output valid, output command, output gate, input ready);
  modport sink   (input valid, input command, input gate, output ready);
endinterface

// Result channel: valid/ready with level and phase
interface adsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [2:0] phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

/* sv/adsr_step_calc.sv */
module adsr_step_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 recalc,
  input  adsr_pkg::adsr_knobs_t knobs,
  output adsr_pkg::adsr_steps_t steps
);
  import adsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LOAD_ATK = 7'b0000010,
    S_RUN_ATK  = 7'b0000100,
    S_LOAD_DEC = 7'b0001000,
    S_RUN_DEC  = 7'b0010000,
    S_LOAD_REL = 7'b0100000,
    S_RUN_REL  = 7'b1000000
  } calc_state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

  calc_state_t state_r, state_nxt;
  logic        req_r, req_nxt;

  // Restoring divider: dividend shifts out the top, quotient shifts in the bottom
  logic [DIV_BITS-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0]    rem_r, rem_nxt;
  logic [DSR_W-1:0]    dsr_r, dsr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [ATK_W-1:0] atk_r, atk_nxt;
  logic [DEC_W-1:0] dec_r, dec_nxt;
  logic [REL_W-1:0] rel_r, rel_nxt;

  logic [DSR_W:0]      rem_sh;
  logic                q_bit;
  logic [DIV_BITS-1:0] dvd_step;
  logic [DSR_W-1:0]    rem_step;
  logic [DSR_W-1:0]    dec_dsr;
  logic [20:0]         rel_prod;
  logic                run;
  logic                last;

  // One divider iteration
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DIV_BITS-1]};
    q_bit    = (rem_sh >= {1'b0, dsr_r});
    rem_step = q_bit ? DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSR_W-1:0];
    dvd_step = {dvd_r[DIV_BITS-2:0], q_bit};
  end

  // Operand products, registered into the divider on load
  always_comb begin
    dec_dsr  = DSR_W'(knob_div(knobs.decay)) * DSR_W'(DEC_SCALE);
    rel_prod = 21'(knobs.sustain) * 21'(ATK_NUM);
  end

  assign run  = (state_r == S_RUN_ATK) || (state_r == S_RUN_DEC) || (state_r == S_RUN_REL);
  assign last = run && (cnt_r == CNT_LAST);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r | recalc;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    cnt_nxt   = cnt_r;
    atk_nxt   = atk_r;
    dec_nxt   = dec_r;
    rel_nxt   = rel_r;

    if (run) begin
      dvd_nxt = dvd_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (req_r) begin
          req_nxt   = recalc;
          state_nxt = S_LOAD_ATK;
        end
      end
      S_LOAD_ATK: begin
        dvd_nxt   = DIV_BITS'(ATK_NUM);
        dsr_nxt   = DSR_W'(knob_div(knobs.attack));
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_RUN_ATK;
      end
      S_RUN_ATK: begin
        if (last) begin
          atk_nxt   = dvd_step[ATK_W-1:0];
          state_nxt = S_LOAD_DEC;
        end
      end
      S_LOAD_DEC: begin
        // (255 - sustain) << 11 equals cap minus sustain level
        dvd_nxt   = DIV_BITS'({8'd255 - knobs.sustain, {SUS_SHIFT{1'b0}}});
        dsr_nxt   = dec_dsr;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_RUN_DEC;
      end
      S_RUN_DEC: begin
        if (last) begin
          dec_nxt   = dvd_step[DEC_W-1:0];
          state_nxt = S_LOAD_REL;
        end
      end
      S_LOAD_REL: begin
        dvd_nxt   = {rel_prod, {SUS_SHIFT{1'b0}}};
        dsr_nxt   = DSR_W'(knob_div(knobs.rel));
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_RUN_REL;
      end
      S_RUN_REL: begin
        if (last) begin
          rel_nxt   = dvd_step[REL_SHIFT +: REL_W];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    atk_r <= atk_nxt;
    dec_r <= dec_nxt;
    rel_r <= rel_nxt;
  end

  assign steps.busy     = (state_r != S_IDLE) || req_r;
  assign steps.atk_step = atk_r;
  assign steps.dec_step = dec_r;
  assign steps.rel_step = rel_r;

endmodule

/* sv/adsr_envelope_generator.sv */
// Linear ADSR envelope generator. Each transfer on the command channel is a gate
// update (command 0) or one envelope tick (command 1), and yields exactly one
// transfer of level and phase on the result channel, in order. Once the step unit
// is idle the block takes one command per cycle: the envelope update is a single
// add or subtract with a compare between the command handshake and the result
// register, and a new command is taken in the same cycle that a waiting result is
// taken. The attack, decay and release steps come from a shared restoring divider
// run three times in sequence; after reset and after every knob write over the
// APB port the command channel holds ready low while the steps are recomputed.
// Knob writes are meant for idle periods.
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  adsr_in_if.sink                        in_ch,
  adsr_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [adsr_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [adsr_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [adsr_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import adsr_pkg::*;

  adsr_knobs_t knobs_r, knobs_nxt;
  adsr_steps_t steps;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  logic             gate_r, gate_nxt;
  env_phase_t       phase_r, phase_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] level_r;
  logic [PHASE_W-1:0] phase_out_r;

  logic             in_xfer;
  logic [ACC_W-1:0] sus_lvl;
  logic [ACC_W:0]   atk_sum;
  logic [ACC_W-1:0] dec_acc;
  logic [ACC_W-1:0] rel_ext;

  // APB register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    knobs_nxt = knobs_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK:  knobs_nxt.attack  = cfg_pwdata[KNOB_W-1:0];
        REG_DECAY:   knobs_nxt.decay   = cfg_pwdata[KNOB_W-1:0];
        REG_SUSTAIN: knobs_nxt.sustain = cfg_pwdata[KNOB_W-1:0];
        REG_RELEASE: knobs_nxt.rel     = cfg_pwdata[KNOB_W-1:0];
        default:     knobs_nxt = knobs_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:  cfg_prdata = PDATA_W'(knobs_r.attack);
      REG_DECAY:   cfg_prdata = PDATA_W'(knobs_r.decay);
      REG_SUSTAIN: cfg_prdata = PDATA_W'(knobs_r.sustain);
      REG_RELEASE: cfg_prdata = PDATA_W'(knobs_r.rel);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knobs_r <= '{attack: ATTACK_RST, decay: DECAY_RST,
                   sustain: SUSTAIN_RST, rel: RELEASE_RST};
    end else begin
      knobs_r <= knobs_nxt;
    end
  end

  // Step derivation
  adsr_step_calc u_step_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .recalc (cfg_wr),
    .knobs  (knobs_r),
    .steps  (steps)
  );

  // Handshake: output register frees when taken
  assign in_ch.ready = !steps.busy && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Envelope update
  always_comb begin
    sus_lvl   = {knobs_r.sustain, {SUS_SHIFT{1'b0}}};
    atk_sum   = {1'b0, acc_r} + (ACC_W + 1)'(steps.atk_step);
    dec_acc   = (acc_r >= steps.dec_step) ? (acc_r - steps.dec_step) : '0;
    rel_ext   = ACC_W'(steps.rel_step);
    gate_nxt  = gate_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;

    if (!in_ch.command) begin
      // Gate edges only
      if (in_ch.gate && !gate_r) begin
        gate_nxt  = 1'b1;
        phase_nxt = ENV_ATTACK;
      end else if (!in_ch.gate && gate_r) begin
        gate_nxt  = 1'b0;
        phase_nxt = ENV_RELEASE;
      end
    end else begin
      unique case (phase_r)
        ENV_ATTACK: begin
          if (atk_sum > (ACC_W + 1)'(ENV_CAP)) begin
            acc_nxt   = ENV_CAP;
            phase_nxt = ENV_DECAY;
          end else begin
            acc_nxt = atk_sum[ACC_W-1:0];
          end
        end
        ENV_DECAY: begin
          if (dec_acc <= sus_lvl) begin
            acc_nxt   = sus_lvl;
            phase_nxt = ENV_SUSTAIN;
          end else begin
            acc_nxt = dec_acc;
          end
        end
        ENV_RELEASE: begin
          if (acc_r >= rel_ext) begin
            acc_nxt = acc_r - rel_ext;
          end else begin
            acc_nxt   = '0;
            phase_nxt = ENV_INACTIVE;
          end
        end
        ENV_INACTIVE, ENV_SUSTAIN: begin
          acc_nxt = acc_r;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= 1'b0;
      phase_r <= ENV_INACTIVE;
      acc_r   <= '0;
    end else if (in_xfer) begin
      gate_r  <= gate_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      level_r     <= acc_nxt[ACC_W-1 -: LEVEL_W];
      phase_out_r <= phase_code(phase_nxt);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = level_r;
  assign out_ch.phase = phase_out_r;

  // Checks
  `ADSR_ASSERT_IMP(a_acc_cap, clk, rst_n, 1'b1, acc_r <= ENV_CAP)
  `ADSR_ASSERT_IMP(a_inactive_zero, clk, rst_n, phase_r == ENV_INACTIVE, acc_r == '0)
  `ADSR_ASSERT_NXT(a_cfg_blocks_cmd, clk, rst_n, cfg_wr, !in_ch.ready)

endmodule
